// ===== design/sss_pkg.sv =====
// shared types, constants and codes for the servo sine sweep generator
package sss_pkg;

   localparam int ELAPSED_W  = 26;
   localparam int PERIOD_W   = 24;
   localparam int DELTA_W    = 16;
   localparam int GAIN_W     = 15;
   localparam int DRIVE_W    = 16;
   localparam int OPND_W     = 15;
   localparam int PROD_W     = 2 * OPND_W;
   localparam int ANGLE_W    = 16;
   localparam int FRAC_W     = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int DEF_PHASE_BITS   = 10;
   localparam int DEF_STOP_DIVISOR = 16;

   // quarter-wave polynomial coefficients, q14
   localparam logic [OPND_W-1:0] SIN_A   = 15'd25736;
   localparam logic [OPND_W-1:0] SIN_B   = 15'd10512;
   localparam logic [OPND_W-1:0] SIN_C   = 15'd1160;
   localparam logic [OPND_W-1:0] QUARTER = 15'd16384;
   localparam logic [OPND_W-1:0] MAG_MAX = 15'd32767;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 15'd32767;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE        = 2'd0,
      CSR_MAX_GAIN    = 2'd1,
      CSR_BASE_PERIOD = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_OSC   = 1'b0,
      MODE_DANCE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SINE,
      ST_FIN
   } ctrl_state_type;

   typedef enum logic [3:0] {
      SN_IDLE,
      SN_X2,
      SN_C,
      SN_T,
      SN_Y,
      SN_M,
      SN_CAP,
      SN_G,
      SN_RND,
      SN_DONE
   } sine_state_type;

   typedef struct packed {
      logic              start;
      logic              use_gain;
      logic [GAIN_W-1:0] gain;
   } sine_cmd_type;

   typedef struct packed {
      logic              done;
      logic              neg;
      logic [OPND_W-1:0] mag;
   } sine_stat_type;

endpackage

// ===== design/sss_req_if.sv =====
// step event channel: valid, ready and the time delta word
interface sss_req_if;
   import sss_pkg::*;

   logic               valid;
   logic               ready;
   logic [DELTA_W-1:0] time_delta;

   modport source (output valid, output time_delta, input ready);
   modport sink   (input valid, input time_delta, output ready);
endinterface

// ===== design/sss_rsp_if.sv =====
// drive result channel: valid, ready, drive value and restart flag
interface sss_rsp_if;
   import sss_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      cycle_restart;

   modport source (output valid, output drive, output cycle_restart, input ready);
   modport sink   (input valid, input drive, input cycle_restart, output ready);
endinterface

// ===== design/sss_div.sv =====
// bit-serial restoring divider giving the low phase bits of elapsed << shift / period
module sss_div #(
   parameter int PHASE_BITS = sss_pkg::DEF_PHASE_BITS,
   parameter int HALV_W     = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sss_pkg::ELAPSED_W-1:0] dividend,
   input  logic [HALV_W-1:0]             halving,
   input  logic [sss_pkg::PERIOD_W-1:0]  period,
   output logic                          done,
   output logic [PHASE_BITS-1:0]         quot
);
   import sss_pkg::*;

   localparam int MAX_STEPS = ELAPSED_W + (2 ** HALV_W) - 1 + PHASE_BITS;
   localparam int CNT_W     = $clog2(MAX_STEPS + 1);

   logic [ELAPSED_W-1:0]  num_ff, num_in;
   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [PHASE_BITS-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   logic [PERIOD_W:0]     trial;
   logic [PERIOD_W:0]     diff;
   logic                  fits;
   logic [CNT_W-1:0]      steps;

   always_comb begin
      trial = {rem_ff, num_ff[ELAPSED_W-1]};
      fits  = trial >= {1'b0, period};
      diff  = trial - {1'b0, period};
      steps = CNT_W'(ELAPSED_W) + CNT_W'(halving) + CNT_W'(PHASE_BITS);

      num_in  = num_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = steps;
      end else if (cnt_ff != '0) begin
         // one quotient bit per cycle, remainder stays below the period
         num_in  = num_ff << 1;
         rem_in  = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         quot_in = {quot_ff[PHASE_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ===== design/sss_sine.sv =====
// quarter-wave sine polynomial and gain scaling on one shared multiplier
module sss_sine #(
   parameter int PHASE_BITS = sss_pkg::DEF_PHASE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sss_pkg::sine_cmd_type cmd,
   input  logic [PHASE_BITS-1:0] phase,
   output sss_pkg::sine_stat_type stat
);
   import sss_pkg::*;

   localparam logic [PROD_W:0] RND_M = (PROD_W + 1)'(8192);
   localparam logic [PROD_W:0] RND_G = (PROD_W + 1)'(16384);

   sine_state_type      state_ff, state_in;
   logic [OPND_W-1:0]   x_ff, x_in;
   logic [OPND_W-1:0]   x2_ff, x2_in;
   logic                neg_ff, neg_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [OPND_W-1:0]   mag_ff, mag_in;

   logic [OPND_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]   product;
   logic [OPND_W-1:0]   prod_hi;
   logic [ANGLE_W-1:0]  angle;
   logic [OPND_W-1:0]   x_raw;
   logic [PROD_W:0]     sum_m, sum_g;
   logic [PROD_W-FRAC_W:0] scaled;

   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_hi = prod_ff[FRAC_W+OPND_W-1:FRAC_W];
   assign angle   = ANGLE_W'(phase) << (ANGLE_W - PHASE_BITS);
   assign x_raw   = {1'b0, angle[FRAC_W-1:0]};
   assign sum_m   = {1'b0, prod_ff} + RND_M;
   assign sum_g   = {1'b0, prod_ff} + RND_G;
   assign scaled  = sum_m[PROD_W:FRAC_W];

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      mag_in   = mag_ff;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         SN_IDLE: begin
            if (cmd.start) begin
               // mirror in odd quadrants, negative in the lower half turn
               x_in     = angle[FRAC_W] ? QUARTER - x_raw : x_raw;
               neg_in   = angle[ANGLE_W-1];
               state_in = SN_X2;
            end
         end
         SN_X2: begin
            mul_a    = x_ff;
            mul_b    = x_ff;
            prod_in  = product;
            state_in = SN_C;
         end
         SN_C: begin
            x2_in    = prod_hi;
            mul_a    = prod_hi;
            mul_b    = SIN_C;
            prod_in  = product;
            state_in = SN_T;
         end
         SN_T: begin
            mul_a    = x2_ff;
            mul_b    = SIN_B - prod_hi;
            prod_in  = product;
            state_in = SN_Y;
         end
         SN_Y: begin
            mul_a    = x_ff;
            mul_b    = SIN_A - prod_hi;
            prod_in  = product;
            state_in = SN_M;
         end
         SN_M: begin
            mul_a    = prod_hi;
            mul_b    = MAG_MAX;
            prod_in  = product;
            state_in = SN_CAP;
         end
         SN_CAP: begin
            mag_in   = (scaled > (PROD_W - FRAC_W + 1)'(MAG_MAX)) ? MAG_MAX
                                                                 : scaled[OPND_W-1:0];
            state_in = cmd.use_gain ? SN_G : SN_DONE;
         end
         SN_G: begin
            mul_a    = mag_ff;
            mul_b    = cmd.gain;
            prod_in  = product;
            state_in = SN_RND;
         end
         SN_RND: begin
            mag_in   = sum_g[GAIN_W+OPND_W-1:GAIN_W];
            state_in = SN_DONE;
         end
         SN_DONE: begin
            state_in = SN_IDLE;
         end
         default: begin
            state_in = SN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      mag_ff  <= mag_in;
   end

   assign stat.done = (state_ff == SN_DONE);
   assign stat.neg  = neg_ff;
   assign stat.mag  = mag_ff;
endmodule

// ===== design/servo_sine_sweep_generator.sv =====
// servo sine sweep generator top level: control, timer state and result register
//
//   port       dir   word                          handshake
//   req_chan   in    time_delta (16b unsigned)     valid / ready
//   rsp_chan   out   drive (16b signed), restart   valid / ready
//   csr_*      in    index 2b, data 24b            write enable, no wait
//
// one step word at a time: ready only while the sequencer is idle
// each word passes the bit-serial phase divider (one quotient bit per cycle)
//   and the shared sine multiplier, whose gain stage is skipped in dance mode;
//   the sequencer is idle again, ready for the next word, in the same cycle
//   that the drive word is first offered
// the result register frees the sequencer: a new word is taken while
//   a finished drive word still waits on a stalled rsp_chan
// synchronous active-high reset: timer stopped, elapsed zero, registers
//   at mode oscillate, gain 32767, period 1000
module servo_sine_sweep_generator #(
   parameter int PHASE_BITS   = sss_pkg::DEF_PHASE_BITS,
   parameter int STOP_DIVISOR = sss_pkg::DEF_STOP_DIVISOR
) (
   input  logic                           clock,
   input  logic                           reset,
   sss_req_if.sink                        req_chan,
   sss_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [sss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sss_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import sss_pkg::*;

   // halving stops once 2^h reaches the stop divisor
   localparam int HALV_MAX = $clog2(STOP_DIVISOR);
   localparam int HALV_W   = $clog2(HALV_MAX + 1);

   ctrl_state_type             state_ff, state_in;

   // configuration registers
   mode_type                   mode_ff, mode_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic [PERIOD_W-1:0]        period_ff, period_in;

   // timer state
   logic [ELAPSED_W-1:0]       elapsed_ff, elapsed_in;
   logic [HALV_W-1:0]          halving_ff, halving_in;
   logic                       running_ff, running_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;
   logic                       restart_ff, restart_in;

   logic                       accept;
   logic [PERIOD_W-1:0]        period_eff;
   logic [ELAPSED_W-1:0]       elapsed_sum;
   logic [HALV_W-1:0]          div_halving;
   logic                       div_done;
   logic [PHASE_BITS-1:0]      phase;
   sine_cmd_type               sine_cmd;
   sine_stat_type              sine_stat;
   logic                       over_osc, over_dance, restart;
   logic [HALV_W-1:0]          halving_next;
   logic                       slot_free;
   logic [DRIVE_W-1:0]         mag_ext;

   assign accept      = req_chan.valid && req_chan.ready;
   assign period_eff  = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign elapsed_sum = elapsed_ff + ELAPSED_W'(req_chan.time_delta);
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;

   // restart tests against one period (oscillate) or two periods (dance)
   assign over_osc   = elapsed_ff > ELAPSED_W'(period_eff);
   assign over_dance = elapsed_ff > {1'b0, period_eff, 1'b0};
   assign restart    = (mode_ff == MODE_OSC) ? over_osc : over_dance;
   assign halving_next = (mode_ff == MODE_DANCE && restart && halving_ff < HALV_W'(HALV_MAX))
                         ? halving_ff + 1'b1 : halving_ff;
   assign mag_ext = {1'b0, sine_stat.mag};

   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      halving_in   = halving_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      drive_in     = drive_ff;
      restart_in   = restart_ff;
      div_halving  = '0;
      sine_cmd.start    = 1'b0;
      sine_cmd.use_gain = (mode_ff == MODE_OSC);
      sine_cmd.gain     = gain_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (mode_ff == MODE_OSC) begin
                  elapsed_in = elapsed_sum;
               end else if (!running_ff) begin
                  // dance start: drop this delta, sweep from base period
                  running_in = 1'b1;
                  halving_in = '0;
                  elapsed_in = '0;
               end else begin
                  elapsed_in  = elapsed_sum;
                  div_halving = halving_ff;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               sine_cmd.start = 1'b1;
               state_in       = ST_SINE;
            end
         end
         ST_SINE: begin
            if (sine_stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               restart_in   = restart;
               if (restart) begin
                  drive_in   = '0;
                  elapsed_in = '0;
               end else if (sine_stat.neg) begin
                  drive_in = $signed(DRIVE_W'(0) - mag_ext);
               end else begin
                  drive_in = $signed(mag_ext);
               end
               if (mode_ff == MODE_DANCE) begin
                  halving_in = halving_next;
                  if (halving_next >= HALV_W'(HALV_MAX)) begin
                     running_in = 1'b0;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      mode_in   = mode_ff;
      gain_in   = gain_ff;
      period_in = period_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:        mode_in   = mode_type'(csr_wr_data[0]);
            CSR_MAX_GAIN:    gain_in   = csr_wr_data[GAIN_W-1:0];
            CSR_BASE_PERIOD: period_in = csr_wr_data[PERIOD_W-1:0];
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_OSC;
         gain_ff      <= GAIN_RESET;
         period_ff    <= PERIOD_RESET;
         elapsed_ff   <= '0;
         halving_ff   <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         period_ff    <= period_in;
         elapsed_ff   <= elapsed_in;
         halving_ff   <= halving_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drive_ff   <= drive_in;
      restart_ff <= restart_in;
   end

   // phase divider: dividend taken straight from the accepted elapsed value
   sss_div #(
      .PHASE_BITS (PHASE_BITS),
      .HALV_W     (HALV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (elapsed_in),
      .halving  (div_halving),
      .period   (period_eff),
      .done     (div_done),
      .quot     (phase)
   );

   sss_sine #(
      .PHASE_BITS (PHASE_BITS)
   ) u_sine (
      .clock (clock),
      .reset (reset),
      .cmd   (sine_cmd),
      .phase (phase),
      .stat  (sine_stat)
   );

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.drive         = drive_ff;
   assign rsp_chan.cycle_restart = restart_ff;

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DIV)
      else $error("accepted word did not start the divider");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.cycle_restart) |-> rsp_chan.drive == '0)
      else $error("restart word with nonzero drive");

   a_halving_bound: assert property (@(posedge clock) disable iff (reset)
      halving_ff <= HALV_W'(HALV_MAX))
      else $error("halving count beyond stop level");

   a_osc_keeps_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_OSC) |=> ($stable(halving_ff) && $stable(running_ff)))
      else $error("oscillate word changed sweep state");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.drive != {1'b1, {(DRIVE_W-1){1'b0}}})
      else $error("drive at most negative code");
endmodule

// ===== test/sss_drive_checker.sv =====
// drive word scoreboard: follows register writes and step words, predicts and checks every drive word
`timescale 1ns / 1ps
module sss_drive_checker #(
   parameter int PHASE_BITS   = sss_pkg::DEF_PHASE_BITS,
   parameter int STOP_DIVISOR = sss_pkg::DEF_STOP_DIVISOR
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [sss_pkg::DELTA_W-1:0]           req_time_delta,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [sss_pkg::DRIVE_W-1:0]    rsp_drive,
   input  logic                                  rsp_cycle_restart,
   input  logic                                  csr_wr_en,
   input  logic [sss_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sss_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   output int                                    fail_count,
   output int                                    drives_checked,
   output int                                    drives_owed,
   output int                                    restarts_seen
);
   import sss_pkg::*;

   typedef struct {
      logic signed [DRIVE_W-1:0] drive;
      logic                      cycle_restart;
   } drive_word_type;

   // quarter-wave polynomial, q14
   localparam logic [63:0] POLY_A = 64'd25736;
   localparam logic [63:0] POLY_B = 64'd10512;
   localparam logic [63:0] POLY_C = 64'd1160;
   localparam int          MAX_HALVINGS = 8;

   mode_type              cfg_mode;
   logic [GAIN_W-1:0]     cfg_gain;
   logic [PERIOD_W-1:0]   cfg_period;
   logic [ELAPSED_W-1:0]  elapsed_ticks;
   int unsigned           halvings;
   bit                    timer_on;

   drive_word_type        owed_q[$];
   int                    fails;
   int                    checked;
   int                    restarts;

   function automatic logic [14:0] sine_magnitude(input logic [ANGLE_W-1:0] angle,
                                                  output bit negative);
      logic [63:0] x, x2, t, y, m;
      x = {50'd0, angle[13:0]};
      if (angle[14])
         x = 64'd16384 - x;
      negative = angle[15];
      x2 = (x * x) >> 14;
      t  = POLY_B - ((x2 * POLY_C) >> 14);
      t  = (x2 * t) >> 14;
      y  = (x * (POLY_A - t)) >> 14;
      m  = (y * 64'd32767 + 64'd8192) >> 14;
      if (m > 64'd32767)
         m = 64'd32767;
      return m[14:0];
   endfunction

   function automatic logic [ANGLE_W-1:0] turn_angle(input logic [ELAPSED_W-1:0] el,
                                                     input int unsigned h,
                                                     input logic [PERIOD_W-1:0] period);
      logic [63:0] num, p;
      num = {38'd0, el} << (h + PHASE_BITS);
      p   = (num / {40'd0, period}) & ((64'd1 << PHASE_BITS) - 64'd1);
      return ANGLE_W'(p << (ANGLE_W - PHASE_BITS));
   endfunction

   // advances the timer state by one step word and returns the drive word it yields
   function automatic drive_word_type predict_step(input logic [DELTA_W-1:0] delta);
      drive_word_type      word;
      logic [PERIOD_W-1:0] period;
      logic [63:0]         scaled;
      logic [14:0]         mag;
      bit                  neg;
      bit                  restart;
      int unsigned         h;
      period  = (cfg_period == '0) ? 24'd1 : cfg_period;
      restart = 1'b0;
      if (cfg_mode == MODE_OSC) begin
         elapsed_ticks = elapsed_ticks + ELAPSED_W'(delta);
         mag    = sine_magnitude(turn_angle(elapsed_ticks, 0, period), neg);
         scaled = ({49'd0, mag} * {49'd0, cfg_gain} + 64'd16384) >> 15;
         mag    = scaled[14:0];
         if ({38'd0, elapsed_ticks} > {40'd0, period}) begin
            elapsed_ticks = '0;
            restart       = 1'b1;
         end
      end else begin
         if (!timer_on) begin
            timer_on      = 1'b1;
            halvings      = 0;
            elapsed_ticks = '0;
         end else begin
            elapsed_ticks = elapsed_ticks + ELAPSED_W'(delta);
         end
         h   = (halvings > MAX_HALVINGS) ? MAX_HALVINGS : halvings;
         mag = sine_magnitude(turn_angle(elapsed_ticks, h, period), neg);
         if ({38'd0, elapsed_ticks} > ({40'd0, period} << 1)) begin
            elapsed_ticks = '0;
            restart       = 1'b1;
            if (halvings < MAX_HALVINGS)
               halvings++;
         end
         h = (halvings > MAX_HALVINGS) ? MAX_HALVINGS : halvings;
         if ((64'd1 << h) >= STOP_DIVISOR)
            timer_on = 1'b0;
      end
      if (restart)
         mag = '0;
      word.drive         = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      word.cycle_restart = restart;
      return word;
   endfunction

   always @(posedge clock) begin
      drive_word_type want;
      if (reset) begin
         cfg_mode      = MODE_OSC;
         cfg_gain      = 15'd32767;
         cfg_period    = 24'd1000;
         elapsed_ticks = '0;
         halvings      = 0;
         timer_on      = 1'b0;
         owed_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:        cfg_mode   = mode_type'(csr_wr_data[0]);
               CSR_MAX_GAIN:    cfg_gain   = csr_wr_data[GAIN_W-1:0];
               CSR_BASE_PERIOD: cfg_period = csr_wr_data[PERIOD_W-1:0];
               default: ;
            endcase
         end
         // results first, so a word taken at this edge cannot cover a stray result
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (rsp_cycle_restart === 1'b1)
               restarts++;
            if (owed_q.size() == 0) begin
               fails++;
               $display("%0t drive word with none owed: drive %0d restart %0b", $time,
                        rsp_drive, rsp_cycle_restart);
            end else begin
               want = owed_q.pop_front();
               if (rsp_drive !== want.drive) begin
                  fails++;
                  $display("%0t drive mismatch: expected %0d, actual %0d", $time,
                           want.drive, rsp_drive);
               end
               if (rsp_cycle_restart !== want.cycle_restart) begin
                  fails++;
                  $display("%0t cycle_restart mismatch: expected %0b, actual %0b", $time,
                           want.cycle_restart, rsp_cycle_restart);
               end
            end
         end
         if (req_valid && req_ready)
            owed_q.push_back(predict_step(req_time_delta));
      end
      fail_count     <= fails;
      drives_checked <= checked;
      drives_owed    <= owed_q.size();
      restarts_seen  <= restarts;
   end

endmodule

// ===== test/servo_sine_sweep_generator_tb.sv =====
// testbench top: clock, reset, register programming, step word stimulus and the verdict
`timescale 1ns / 1ps
module servo_sine_sweep_generator_tb;
   import sss_pkg::*;

   localparam int RANDOM_STEPS = 1650;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // shared knobs: calm turns off idling on both sides, hold_asked triggers the long stall
   logic                  calm;
   logic                  hold_asked;
   bit                    hold_served;

   int                    steps_sent;
   int                    settings_used;
   int                    fail_count;
   int                    drives_checked;
   int                    drives_owed;
   int                    restarts_seen;

   sss_req_if req_chan ();
   sss_rsp_if rsp_chan ();

   servo_sine_sweep_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   sss_drive_checker drive_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_time_delta    (req_chan.time_delta),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_drive         (rsp_chan.drive),
      .rsp_cycle_restart (rsp_chan.cycle_restart),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .drives_checked    (drives_checked),
      .drives_owed       (drives_owed),
      .restarts_seen     (restarts_seen)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit, far above the slowest legal run (about 1700 words)
   initial begin
      #12_000_000;
      $display("FAILURE");
      $finish;
   end

   // offer one step word, maybe after a short random gap, and hold it until taken
   task automatic send_step(input logic [DELTA_W-1:0] delta);
      if (!calm && $urandom_range(99) < 10) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.time_delta <= delta;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      steps_sent++;
   endtask

   // one register write per clock, enable left high for back-to-back writes
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   // registers only change with the block idle: stop offering, wait for every drive word
   task automatic program_regs(input mode_type m, input logic [GAIN_W-1:0] gain,
                               input logic [PERIOD_W-1:0] period);
      req_chan.valid <= 1'b0;
      while (drives_checked < steps_sent)
         @(posedge clock);
      write_reg(CSR_MODE, {{(CSR_DATA_W-1){1'b0}}, m});
      write_reg(CSR_MAX_GAIN, {{(CSR_DATA_W-GAIN_W){1'b0}}, gain});
      write_reg(CSR_BASE_PERIOD, period);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // mostly short periods so restarts and full dance sweeps happen often
   function automatic logic [PERIOD_W-1:0] pick_period();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)
         return '0;
      if (r < 10)
         return 24'd1;
      if (r < 15)
         return 24'hFFFFFF;
      if (r < 20)
         return PERIOD_W'($urandom_range(24'hFFFFFF));
      if (r < 55)
         return PERIOD_W'($urandom_range(64, 2));
      return PERIOD_W'($urandom_range(20000, 65));
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15)
         return '0;
      if (r < 30)
         return 15'h7FFF;
      return GAIN_W'($urandom_range(15'h7FFF));
   endfunction

   // deltas scaled to the period walk through the whole wave; some are full-range noise
   function automatic logic [DELTA_W-1:0] pick_delta(input logic [PERIOD_W-1:0] period);
      int unsigned r;
      int unsigned span;
      r = $urandom_range(99);
      if (r < 5)
         return '0;
      if (r < 10)
         return 16'hFFFF;
      if (r < 25)
         return DELTA_W'($urandom_range(16'hFFFF));
      span = period / 5 + 2;
      if (span > 16'hFFFF)
         span = 16'hFFFF;
      return DELTA_W'($urandom_range(span));
   endfunction

   // result side: random stalls, none while calm, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked && !hold_served) begin
            hold_served = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   initial begin
      int              random_steps;
      int              phase_no;
      int              n;
      mode_type        m;
      logic [GAIN_W-1:0]   gain;
      logic [PERIOD_W-1:0] period;

      random_steps  = 0;
      phase_no      = 0;
      steps_sent    = 0;
      settings_used = 0;

      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.time_delta <= '0;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_MODE;
      csr_wr_data         <= '0;
      calm                <= 1'b0;
      hold_asked          <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings (oscillate, gain 32767, period 1000): quarter points,
      // landing exactly on the period, one past it, and a maximal delta
      send_step(16'd0);
      send_step(16'd250);
      send_step(16'd250);
      send_step(16'd250);
      send_step(16'd250);
      send_step(16'd1);
      send_step(16'hFFFF);
      send_step(16'd500);

      // zero period behaves as one tick, zero gain silences the drive
      program_regs(MODE_OSC, 15'd0, 24'd0);
      send_step(16'd0);
      send_step(16'd1);
      send_step(16'd1);

      // dance: start word drops its delta, two words per halving, timer stops
      // after the fourth restart and the next word starts a fresh sweep
      program_regs(MODE_DANCE, 15'd12345, 24'd8);
      send_step(16'hFFFF);
      repeat (8) send_step(16'd9);
      send_step(16'hFFFF);

      // back to oscillate with the dance timer left running, widest period, full gain
      program_regs(MODE_OSC, 15'h7FFF, 24'hFFFFFF);
      send_step(16'hFFFF);
      send_step(16'hFFFF);
      send_step(16'd0);

      // random settings, each followed by a run of step words
      while (random_steps < RANDOM_STEPS) begin
         phase_no++;
         m      = $urandom_range(1) ? MODE_DANCE : MODE_OSC;
         gain   = pick_gain();
         period = pick_period();
         program_regs(m, gain, period);
         calm <= (phase_no == 4);
         if (phase_no == 2)
            hold_asked <= 1'b1;
         n = (period > 24'd100000) ? $urandom_range(30, 10) : $urandom_range(120, 40);
         repeat (n) begin
            send_step(pick_delta(period));
            random_steps++;
         end
      end

      // drain, then give a stray late word time to show up
      req_chan.valid <= 1'b0;
      while (drives_checked < steps_sent)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d step words under %0d register settings,", steps_sent,
               settings_used);
      $display("%0d drive words checked, %0d of them timer restarts", drives_checked,
               restarts_seen);
      if (fail_count == 0 && drives_owed == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
design/sss_pkg.sv
design/sss_req_if.sv
design/sss_rsp_if.sv
design/sss_div.sv
design/sss_sine.sv
design/servo_sine_sweep_generator.sv
test/sss_drive_checker.sv
test/servo_sine_sweep_generator_tb.sv
